[src/rrps_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin process scheduler package
// Shared codes, the table entry layout and the request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

package rrps_pkg;

   localparam int TABLE_SLOTS_DEF = 16;

   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int PID_W    = 16;
   localparam int WAIT_W   = 17;
   localparam int STATE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int OSLOT_W  = 4;

   localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd1;
   localparam logic [OP_W-1:0] OP_BLOCK    = 3'd2;
   localparam logic [OP_W-1:0] OP_WAKE     = 3'd3;
   localparam logic [OP_W-1:0] OP_FIND     = 3'd4;
   localparam logic [OP_W-1:0] OP_NEXT_PID = 3'd5;

   localparam logic [STATE_W-1:0] ST_READY   = 2'd0;
   localparam logic [STATE_W-1:0] ST_RUNNING = 2'd1;
   localparam logic [STATE_W-1:0] ST_BLOCKED = 2'd2;

   localparam logic [WAIT_W-1:0] WAIT_NONE = 17'h1FFFF;
   localparam logic [PID_W-1:0]  PID_MAX   = 16'hFFFF;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_READY = 2'd2;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [WORD_W-1:0]  stack;
      logic [PID_W-1:0]   pid;
      logic [WAIT_W-1:0]  wait_on;
      logic [WORD_W-1:0]  dir;
      logic [WORD_W-1:0]  kstack;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] stack_value;
      logic [PID_W-1:0]  proc_id;
      logic [WORD_W-1:0] dir_base;
      logic [WORD_W-1:0] kstack_base;
   } req_word_type;

   typedef struct packed {
      logic [WORD_W-1:0]   result_stack;
      logic [WORD_W-1:0]   dir_load;
      logic [WORD_W-1:0]   kstack_load;
      logic [OSLOT_W-1:0]  active_slot;
      logic                active_valid;
      logic [OSLOT_W-1:0]  match_slot;
      logic                match_valid;
      logic [PID_W-1:0]    fresh_pid;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

endpackage

`default_nettype wire

[src/rrps_if.sv]
// ----------------------------------------------------------------------------
// Round-robin process scheduler channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrps_req_if;
   import rrps_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [WORD_W-1:0] stack_value;
   logic [PID_W-1:0]  proc_id;
   logic [WORD_W-1:0] dir_base;
   logic [WORD_W-1:0] kstack_base;

   modport source (
      output valid, operation, stack_value, proc_id, dir_base, kstack_base,
      input  ready
   );
   modport sink (
      input  valid, operation, stack_value, proc_id, dir_base, kstack_base,
      output ready
   );
endinterface

interface rrps_rsp_if;
   import rrps_pkg::*;

   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   result_stack;
   logic [WORD_W-1:0]   dir_load;
   logic [WORD_W-1:0]   kstack_load;
   logic [OSLOT_W-1:0]  active_slot;
   logic                active_valid;
   logic [OSLOT_W-1:0]  match_slot;
   logic                match_valid;
   logic [PID_W-1:0]    fresh_pid;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, result_stack, dir_load, kstack_load, active_slot, active_valid,
             match_slot, match_valid, fresh_pid, status,
      input  ready
   );
   modport sink (
      input  valid, result_stack, dir_load, kstack_load, active_slot, active_valid,
             match_slot, match_valid, fresh_pid, status,
      output ready
   );
endinterface

`default_nettype wire

[src/rrps_table.sv]
// ----------------------------------------------------------------------------
// Process table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_table #(
   parameter int  TABLE_SLOTS = rrps_pkg::TABLE_SLOTS_DEF,
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [SLOT_W-1:0]    wr_addr,
   input  rrps_pkg::entry_type  wr_data,
   input  logic [SLOT_W-1:0]    rd_addr,
   output rrps_pkg::entry_type  rd_data
);
   import rrps_pkg::*;

   entry_type mem [TABLE_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/rrps_seq.sv]
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the process table one slot per clock and applies each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_seq #(
   parameter int  TABLE_SLOTS = rrps_pkg::TABLE_SLOTS_DEF,
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrps_pkg::req_word_type req_word,
   input  logic                   out_free,
   output logic                   out_load,
   output rrps_pkg::rsp_word_type out_word,
   output logic                   mem_wr_en,
   output logic [SLOT_W-1:0]      mem_wr_addr,
   output rrps_pkg::entry_type    mem_wr_data,
   output logic [SLOT_W-1:0]      mem_rd_addr,
   input  rrps_pkg::entry_type    mem_rd_data
);
   import rrps_pkg::*;

   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int EXT_W = SLOT_W + OSLOT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_CUR   = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]        state_ff, state_in;
   req_word_type      req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [SLOT_W-1:0] iss_idx_ff, iss_idx_in;
   logic [CNT_W-1:0]  iss_left_ff, iss_left_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   rsp_word_type      res_ff, res_in;
   logic [PID_W-1:0]  max_ff, max_in;

   logic [SLOT_W-1:0] iss_next;
   logic [SLOT_W-1:0] cur_succ;
   logic [EXT_W-1:0]  cur_ext;
   logic [EXT_W-1:0]  pend_ext;
   logic [PID_W-1:0]  fresh;
   logic              is_full;

   assign iss_next = ((CNT_W'(iss_idx_ff) + CNT_W'(1)) == count_ff) ? '0
                     : iss_idx_ff + SLOT_W'(1);
   assign cur_succ = ((CNT_W'(cur_ff) + CNT_W'(1)) == count_ff) ? '0
                     : cur_ff + SLOT_W'(1);
   assign cur_ext  = EXT_W'(cur_ff);
   assign pend_ext = EXT_W'(pend_idx_ff);
   assign fresh    = (max_ff == PID_MAX) ? PID_MAX : max_ff + PID_W'(1);
   assign is_full  = (count_ff == CNT_W'(TABLE_SLOTS));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      iss_idx_in   = iss_idx_ff;
      iss_left_in  = iss_left_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      res_in       = res_ff;
      max_in       = max_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_idx_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = iss_idx_ff;
      out_load     = 1'b0;
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = S_START;
            end
         end
         S_START: begin
            res_in      = '0;
            max_in      = '0;
            pend_in     = 1'b0;
            mem_rd_addr = cur_ff;
            iss_idx_in  = '0;
            iss_left_in = count_ff;
            unique case (req_ff.operation) inside
               OP_ADD: begin
                  state_in = S_ADD;
               end
               OP_TICK: begin
                  state_in = cur_valid_ff ? S_CUR : S_SCAN;
               end
               OP_BLOCK: begin
                  state_in = cur_valid_ff ? S_CUR : S_RESP;
               end
               OP_WAKE, OP_FIND, OP_NEXT_PID: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_ADD: begin
            if (is_full) begin
               res_in.status = STATUS_FULL;
            end else begin
               mem_wr_en           = 1'b1;
               mem_wr_addr         = count_ff[SLOT_W-1:0];
               mem_wr_data.state   = ST_READY;
               mem_wr_data.stack   = req_ff.stack_value;
               mem_wr_data.pid     = req_ff.proc_id;
               mem_wr_data.wait_on = WAIT_NONE;
               mem_wr_data.dir     = req_ff.dir_base;
               mem_wr_data.kstack  = req_ff.kstack_base;
               count_in            = count_ff + CNT_W'(1);
            end
            state_in = S_RESP;
         end
         S_CUR: begin
            mem_wr_addr = cur_ff;
            if (mem_rd_data.state == ST_RUNNING) begin
               mem_wr_en = 1'b1;
               if (req_ff.operation == OP_TICK) begin
                  mem_wr_data.state = ST_READY;
                  mem_wr_data.stack = req_ff.stack_value;
               end else begin
                  mem_wr_data.state   = ST_BLOCKED;
                  mem_wr_data.wait_on = {1'b0, req_ff.proc_id};
               end
            end
            if (req_ff.operation == OP_TICK) begin
               iss_idx_in = cur_succ;
               state_in   = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            if (iss_left_ff != '0) begin
               pend_in     = 1'b1;
               pend_idx_in = iss_idx_ff;
               iss_idx_in  = iss_next;
               iss_left_in = iss_left_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               unique case (req_ff.operation)
                  OP_TICK: begin
                     if (mem_rd_data.state == ST_READY) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data.state   = ST_RUNNING;
                        res_in.result_stack = (cur_valid_ff && pend_idx_ff == cur_ff)
                                              ? req_ff.stack_value : mem_rd_data.stack;
                        res_in.dir_load     = mem_rd_data.dir;
                        res_in.kstack_load  = mem_rd_data.kstack;
                        cur_in              = pend_idx_ff;
                        cur_valid_in        = 1'b1;
                        pend_in             = 1'b0;
                        state_in            = S_RESP;
                     end
                  end
                  OP_WAKE: begin
                     if (mem_rd_data.state == ST_BLOCKED &&
                         mem_rd_data.wait_on == {1'b0, req_ff.proc_id}) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_data.state   = ST_READY;
                        mem_wr_data.wait_on = WAIT_NONE;
                     end
                  end
                  OP_FIND: begin
                     if (mem_rd_data.pid == req_ff.proc_id) begin
                        res_in.match_slot  = pend_ext[OSLOT_W-1:0];
                        res_in.match_valid = 1'b1;
                        pend_in            = 1'b0;
                        state_in           = S_RESP;
                     end
                  end
                  OP_NEXT_PID: begin
                     if (mem_rd_data.pid > max_ff) begin
                        max_in = mem_rd_data.pid;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (iss_left_ff == '0) begin
               if (req_ff.operation == OP_TICK) begin
                  res_in.result_stack = req_ff.stack_value;
                  res_in.status       = STATUS_NO_READY;
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_word              = res_ff;
      out_word.active_slot  = cur_valid_ff ? cur_ext[OSLOT_W-1:0] : '0;
      out_word.active_valid = cur_valid_ff;
      out_word.fresh_pid    = (req_ff.operation == OP_NEXT_PID) ? fresh : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
         pend_ff      <= 1'b0;
         iss_left_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         iss_left_ff  <= iss_left_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      iss_idx_ff  <= iss_idx_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
      max_ff      <= max_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_SLOTS))
      else $error("entry count beyond table size");

   a_cur_in_table: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (CNT_W'(cur_ff) < count_ff))
      else $error("current slot outside filled table");

   a_pend_in_table: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(pend_idx_ff) < count_ff))
      else $error("scan read outside filled table");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((CNT_W'(mem_wr_addr) < count_ff) || (state_ff == S_ADD)))
      else $error("table write outside filled table");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && !is_full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not advance entry count");

endmodule

`default_nettype wire

[src/round_robin_process_scheduler.sv]
// ----------------------------------------------------------------------------
// Round-robin process scheduler
// Process table with add, tick, block, wake, find and next-pid operations.
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered with exactly one response
// word. Add passes through the start, add and response states; block passes
// through the start state, the current-slot state when a current slot is
// held, and the response state. Tick, wake, find and next pid walk the
// filled part of the table one slot per clock through the single read port
// of the table memory (find and tick stop at the first hit). A new request
// is taken once the previous response is loaded, even while it still waits.
// There is no clearing pass after reset: only filled slot data is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_process_scheduler #(
   parameter int TABLE_SLOTS = rrps_pkg::TABLE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rrps_req_if.sink   req_ch,
   rrps_rsp_if.source rsp_ch
);
   import rrps_pkg::*;

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   req_word_type      req_word;
   rsp_word_type      out_word;
   logic              out_load;
   logic              out_free;
   logic              seq_ready;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic [SLOT_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   assign req_word.operation   = req_ch.operation;
   assign req_word.stack_value = req_ch.stack_value;
   assign req_word.proc_id     = req_ch.proc_id;
   assign req_word.dir_base    = req_ch.dir_base;
   assign req_word.kstack_base = req_ch.kstack_base;
   assign req_ch.ready         = seq_ready;

   rrps_seq #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (seq_ready),
      .req_word    (req_word),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_word    (out_word),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   rrps_table #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = out_word;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_stack = rsp_word_ff.result_stack;
   assign rsp_ch.dir_load     = rsp_word_ff.dir_load;
   assign rsp_ch.kstack_load  = rsp_word_ff.kstack_load;
   assign rsp_ch.active_slot  = rsp_word_ff.active_slot;
   assign rsp_ch.active_valid = rsp_word_ff.active_valid;
   assign rsp_ch.match_slot   = rsp_word_ff.match_slot;
   assign rsp_ch.match_valid  = rsp_word_ff.match_valid;
   assign rsp_ch.fresh_pid    = rsp_word_ff.fresh_pid;
   assign rsp_ch.status       = rsp_word_ff.status;

endmodule

`default_nettype wire
